[rtl/finger_angle_to_motor_position_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// Finger angle filter assertion macros
// Shared concurrent assertion forms used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef FINGER_ANGLE_TO_MOTOR_POSITION_FILTER_TOP_MACROS_SVH
`define FINGER_ANGLE_TO_MOTOR_POSITION_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FAMPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FAMPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fampf_pkg.sv]
// ----------------------------------------------------------------------------
// Finger angle filter package
// Shared widths, codes and state types of the filter.
// ----------------------------------------------------------------------------
package fampf_pkg;

    localparam int FULL_SCALE_DEF = 10000;
    localparam int ALPHA_BITS_DEF = 10;
    localparam int POS_W          = 14;
    localparam int SENT_W         = 15;
    localparam int ANGLE_W        = 16;
    localparam int NCH            = 6;
    localparam int DZ_W           = 17;
    localparam int MIN_DEADZONE   = 50;
    localparam int DIV_W          = 32;
    localparam int DVS_W          = 18;
    localparam int DIV_STEPS      = 32;
    localparam int ADDR_W         = 5;

    localparam logic       KIND_SAMPLE  = 1'b0;
    localparam logic       KIND_TICK    = 1'b1;
    localparam logic [2:0] FINGER_THUMB = 3'd0;
    localparam logic [2:0] FINGER_PINKY = 3'd4;

    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_ALPHA       = 3'd1,
        REG_DEADZONE    = 3'd2,
        REG_FLEX_MIN    = 3'd3,
        REG_FLEX_MAX    = 3'd4,
        REG_SPREAD_MIN  = 3'd5,
        REG_SPREAD_MAX  = 3'd6,
        REG_STALE_LIMIT = 3'd7
    } reg_addr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLEX,
        S_FDIV,
        S_SPREAD,
        S_SDIV,
        S_TICK,
        S_DDIV,
        S_EMA,
        S_CMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic step;
        logic commit;
    } lane_ctrl_t;

endpackage

[rtl/fampf_if.sv]
// ----------------------------------------------------------------------------
// Finger angle filter channels
// Valid/ready interfaces for sample requests and position results.
// ----------------------------------------------------------------------------
interface fampf_in_if;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [2:0]          finger;
    logic signed [15:0]  flex_first;
    logic signed [15:0]  flex_second;
    logic signed [15:0]  flex_third;
    logic signed [15:0]  spread_angle;

    modport source (output valid, kind, finger, flex_first, flex_second, flex_third,
                    spread_angle, input ready);
    modport sink (input valid, kind, finger, flex_first, flex_second, flex_third,
                  spread_angle, output ready);
endinterface

interface fampf_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] thumb_spread_pos;
    logic [13:0] thumb_bend_pos;
    logic [13:0] index_bend_pos;
    logic [13:0] middle_bend_pos;
    logic [13:0] ring_bend_pos;
    logic [13:0] pinky_bend_pos;

    modport source (output valid, thumb_spread_pos, thumb_bend_pos, index_bend_pos,
                    middle_bend_pos, ring_bend_pos, pinky_bend_pos, input ready);
    modport sink (input valid, thumb_spread_pos, thumb_bend_pos, index_bend_pos,
                  middle_bend_pos, ring_bend_pos, pinky_bend_pos, output ready);
endinterface

[rtl/fampf_div.sv]
// ----------------------------------------------------------------------------
// Finger angle filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fampf_div
    import fampf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg[DVS_W-1:0], q_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, dvs_reg}) : trial;
            q_reg   <= {q_reg[DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/fampf_lane.sv]
// ----------------------------------------------------------------------------
// Finger angle filter lane
// One channel's moving average, last sent value and deadzone check.
// ----------------------------------------------------------------------------
module fampf_lane
    import fampf_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF,
    parameter int ALPHA_BITS = ALPHA_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [ALPHA_BITS:0] alpha,
    input  logic [POS_W-1:0]  raw,
    input  logic [DZ_W-1:0]   dz,
    output logic [POS_W-1:0]  smoothed,
    output logic              hit
);

    localparam int AW = ALPHA_BITS + POS_W + 3;

    logic [POS_W-1:0]        sm_reg;
    logic [POS_W-1:0]        sm_next;
    logic [SENT_W-1:0]       sent_reg;
    logic [AW-1:0]           prod_new;
    logic [AW-1:0]           prod_old;
    logic [AW-1:0]           acc;
    logic [AW-1:0]           p;
    logic signed [POS_W+1:0] diff;
    logic [POS_W+1:0]        absd;

    assign prod_new = AW'(alpha) * AW'(raw);
    assign prod_old = (AW'(1) << ALPHA_BITS) - AW'(alpha);
    assign acc      = prod_new + (prod_old * AW'(sm_reg)) + (AW'(1) << (ALPHA_BITS - 1));
    assign p        = acc >> ALPHA_BITS;
    assign sm_next  = (p > AW'(FULL_SCALE)) ? POS_W'(FULL_SCALE) : p[POS_W-1:0];

    assign diff = $signed({2'b00, sm_reg}) - $signed({sent_reg[SENT_W-1], sent_reg});
    assign absd = diff[POS_W+1] ? (POS_W+2)'(-diff) : diff;
    assign hit  = DZ_W'(absd) >= dz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg   <= '0;
            sent_reg <= '1;
        end
        else
        begin
            if (ctrl.step)
            begin
                sm_reg <= sm_next;
            end
            if (ctrl.commit)
            begin
                sent_reg <= {1'b0, sm_reg};
            end
        end
    end

    assign smoothed = sm_reg;

endmodule

[rtl/finger_angle_to_motor_position_filter_top.sv]
// ----------------------------------------------------------------------------
// Finger angle to motor position filter
// Maps finger samples to raw positions and emits smoothed motor positions.
// ----------------------------------------------------------------------------
// A finger sample request runs one range mapping before the input is ready
// again, and a thumb sample two, because each range mapping that does not
// clamp runs through one shared 32-step restoring divider; a mapping that
// clamps skips its division. A control tick that is enabled and fresh runs
// one division for the deadzone, a state in which six parallel averaging
// lanes step, a compare and, when it emits, the emit, which waits as long as
// the previous result is still held in the output register. A tick with an
// empty flex range skips the division. A tick that is disabled or stale, and
// a sample for a finger out of range, leave the filter in idle. One request
// is processed at a time; a finished result waits in the output register
// while the next request is taken.
`include "finger_angle_to_motor_position_filter_top_macros.svh"

module finger_angle_to_motor_position_filter_top
    import fampf_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF,
    parameter int ALPHA_BITS = ALPHA_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    fampf_in_if.sink          sample,
    fampf_out_if.source       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = (ALPHA_BITS + 1 > 11) ? ALPHA_BITS + 1 : 11;

    logic               enable_reg;
    logic [10:0]        alpha_reg;
    logic [14:0]        deadzone_reg;
    logic signed [15:0] flex_min_reg;
    logic signed [15:0] flex_max_reg;
    logic signed [15:0] spread_min_reg;
    logic signed [15:0] spread_max_reg;
    logic [7:0]         stale_reg;
    reg_addr_t          waddr;

    state_t             state_reg, state_next;
    logic               have_data_reg, have_data_next;
    logic [7:0]         ticks_reg, ticks_next, ticks_inc;
    logic [DZ_W-1:0]    dz_reg, dz_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg [NCH];
    logic [POS_W-1:0]   raw_reg [NCH];
    logic               raw_we;
    logic [2:0]         raw_idx;
    logic [POS_W-1:0]   raw_wdata;

    logic [2:0]         finger_reg;
    logic signed [15:0] fa_reg, fb_reg, fc_reg, sp_reg;
    logic               accept;

    logic [18:0]        s_sum;
    logic signed [20:0] flex_num, flex_den;
    logic signed [16:0] sp_num, sp_den, flex_rng;
    logic               div_start, div_busy, div_done;
    logic [DIV_W-1:0]   div_dividend, div_q;
    logic [DVS_W-1:0]   div_divisor;

    logic [CW-1:0]      alpha_ext, one_c, a_sat;
    lane_ctrl_t         lane_ctrl;
    logic [NCH-1:0]     hit_vec;
    logic [POS_W-1:0]   sm_vec [NCH];
    logic               emit_load;

    assign pready = 1'b1;
    assign waddr  = reg_addr_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            alpha_reg      <= 11'd307;
            deadzone_reg   <= 15'd200;
            flex_min_reg   <= 16'sd0;
            flex_max_reg   <= 16'sd9000;
            spread_min_reg <= -16'sd3000;
            spread_max_reg <= 16'sd3000;
            stale_reg      <= 8'd10;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (waddr)
                REG_ENABLE:      enable_reg     <= pwdata[0];
                REG_ALPHA:       alpha_reg      <= pwdata[10:0];
                REG_DEADZONE:    deadzone_reg   <= pwdata[14:0];
                REG_FLEX_MIN:    flex_min_reg   <= pwdata[15:0];
                REG_FLEX_MAX:    flex_max_reg   <= pwdata[15:0];
                REG_SPREAD_MIN:  spread_min_reg <= pwdata[15:0];
                REG_SPREAD_MAX:  spread_max_reg <= pwdata[15:0];
                REG_STALE_LIMIT: stale_reg      <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (waddr)
            REG_ENABLE:      prdata = {31'd0, enable_reg};
            REG_ALPHA:       prdata = {21'd0, alpha_reg};
            REG_DEADZONE:    prdata = {17'd0, deadzone_reg};
            REG_FLEX_MIN:    prdata = 32'(flex_min_reg);
            REG_FLEX_MAX:    prdata = 32'(flex_max_reg);
            REG_SPREAD_MIN:  prdata = 32'(spread_min_reg);
            REG_SPREAD_MAX:  prdata = 32'(spread_max_reg);
            REG_STALE_LIMIT: prdata = {24'd0, stale_reg};
        endcase
    end

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            finger_reg <= sample.finger;
            fa_reg     <= sample.flex_first;
            fb_reg     <= sample.flex_second;
            fc_reg     <= sample.flex_third;
            sp_reg     <= sample.spread_angle;
        end
    end

    assign s_sum    = 19'(fa_reg[15] ? -17'(fa_reg) : 17'(fa_reg))
                    + 19'(fb_reg[15] ? -17'(fb_reg) : 17'(fb_reg))
                    + 19'(fc_reg[15] ? -17'(fc_reg) : 17'(fc_reg));
    assign flex_rng = 17'(flex_max_reg) - 17'(flex_min_reg);
    assign flex_num = $signed({2'b00, s_sum}) - 21'(flex_min_reg) * 21'sd3;
    assign flex_den = 21'(flex_rng) * 21'sd3;
    assign sp_num   = 17'(sp_reg) - 17'(spread_min_reg);
    assign sp_den   = 17'(spread_max_reg) - 17'(spread_min_reg);
    assign ticks_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        have_data_next = have_data_reg;
        ticks_next     = ticks_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg;
        raw_we         = 1'b0;
        raw_idx        = finger_reg + 3'd1;
        raw_wdata      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        emit_load      = 1'b0;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.kind == KIND_TICK)
                    begin
                        ticks_next = ticks_inc;
                        if (enable_reg && have_data_reg && (ticks_inc <= stale_reg))
                        begin
                            state_next = S_TICK;
                        end
                    end
                    else if (sample.finger <= FINGER_PINKY)
                    begin
                        have_data_next = 1'b1;
                        ticks_next     = '0;
                        state_next     = S_FLEX;
                    end
                end
            end
            S_FLEX:
            begin
                state_next = (finger_reg == FINGER_THUMB) ? S_SPREAD : S_IDLE;
                raw_we     = 1'b1;
                if (flex_max_reg <= flex_min_reg || flex_num <= 21'sd0)
                begin
                    raw_wdata = '0;
                end
                else if (flex_num >= flex_den)
                begin
                    raw_wdata = POS_W'(FULL_SCALE);
                end
                else
                begin
                    raw_we       = 1'b0;
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(FULL_SCALE) * DIV_W'(flex_num[17:0]);
                    div_divisor  = flex_den[17:0];
                    state_next   = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    raw_we     = 1'b1;
                    raw_wdata  = div_q[POS_W-1:0];
                    state_next = (finger_reg == FINGER_THUMB) ? S_SPREAD : S_IDLE;
                end
            end
            S_SPREAD:
            begin
                state_next = S_IDLE;
                raw_we     = 1'b1;
                raw_idx    = 3'd0;
                if (spread_max_reg <= spread_min_reg || sp_num <= 17'sd0)
                begin
                    raw_wdata = '0;
                end
                else if (sp_num >= sp_den)
                begin
                    raw_wdata = POS_W'(FULL_SCALE);
                end
                else
                begin
                    raw_we       = 1'b0;
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(FULL_SCALE) * DIV_W'(sp_num[15:0]);
                    div_divisor  = DVS_W'(sp_den[15:0]);
                    state_next   = S_SDIV;
                end
            end
            S_SDIV:
            begin
                raw_idx = 3'd0;
                if (div_done)
                begin
                    raw_we     = 1'b1;
                    raw_wdata  = div_q[POS_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (flex_max_reg > flex_min_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(deadzone_reg) * DIV_W'(FULL_SCALE);
                    div_divisor  = DVS_W'(flex_rng[15:0]);
                    state_next   = S_DDIV;
                end
                else
                begin
                    dz_next    = DZ_W'(MIN_DEADZONE);
                    state_next = S_EMA;
                end
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    if (div_q < DIV_W'(MIN_DEADZONE))
                    begin
                        dz_next = DZ_W'(MIN_DEADZONE);
                    end
                    else if (div_q[DIV_W-1:DZ_W] != '0)
                    begin
                        dz_next = '1;
                    end
                    else
                    begin
                        dz_next = div_q[DZ_W-1:0];
                    end
                    state_next = S_EMA;
                end
            end
            S_EMA:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = (|hit_vec) ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    emit_load      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_data_reg <= 1'b0;
            ticks_reg     <= '0;
            dz_reg        <= DZ_W'(MIN_DEADZONE);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                raw_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            have_data_reg <= have_data_next;
            ticks_reg     <= ticks_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
            if (raw_we)
            begin
                raw_reg[raw_idx] <= raw_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                out_pos_reg[i] <= sm_vec[i];
            end
        end
    end

    fampf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign alpha_ext = CW'(alpha_reg);
    assign one_c     = CW'(1) << ALPHA_BITS;
    assign a_sat     = (alpha_ext > one_c) ? one_c : alpha_ext;

    assign lane_ctrl.step   = (state_reg == S_EMA);
    assign lane_ctrl.commit = emit_load;

    for (genvar g = 0; g < NCH; g++)
    begin : g_lane
        fampf_lane #(
            .FULL_SCALE (FULL_SCALE),
            .ALPHA_BITS (ALPHA_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .alpha    (a_sat[ALPHA_BITS:0]),
            .raw      (raw_reg[g]),
            .dz       (dz_reg),
            .smoothed (sm_vec[g]),
            .hit      (hit_vec[g])
        );
    end

    assign result.valid            = out_valid_reg;
    assign result.thumb_spread_pos = out_pos_reg[0];
    assign result.thumb_bend_pos   = out_pos_reg[1];
    assign result.index_bend_pos   = out_pos_reg[2];
    assign result.middle_bend_pos  = out_pos_reg[3];
    assign result.ring_bend_pos    = out_pos_reg[4];
    assign result.pinky_bend_pos   = out_pos_reg[5];

    `FAMPF_ASSERT_NOW(a_div_owner, div_busy, state_reg == S_FDIV || state_reg == S_SDIV || state_reg == S_DDIV, "divider busy outside a division state")
    `FAMPF_ASSERT_NOW(a_dz_floor, state_reg == S_EMA, dz_reg >= DZ_W'(MIN_DEADZONE), "deadzone below minimum")
    `FAMPF_ASSERT_NEXT(a_no_emit, state_reg == S_CMP && hit_vec == '0, state_reg == S_IDLE, "emit without a channel change")
    `FAMPF_ASSERT_NEXT(a_have_data, accept && sample.kind == KIND_SAMPLE && sample.finger <= FINGER_PINKY, have_data_reg && ticks_reg == '0, "sample did not mark data present")

endmodule
